// File: rtl/sru_pkg.sv
`timescale 1ns / 1ps
// sru_pkg: shared types and operation codes for the 36-bit shift/rotate unit.
// No dependencies.
package sru_pkg;

  localparam int WordW  = 36;
  localparam int PairW  = 72;
  localparam int FuncW  = 3;
  localparam int EaW    = 18;
  localparam int KW     = 7;

  localparam logic [FuncW-1:0] FN_ASH  = 3'd0;
  localparam logic [FuncW-1:0] FN_ROT  = 3'd1;
  localparam logic [FuncW-1:0] FN_LSH  = 3'd2;
  localparam logic [FuncW-1:0] FN_ASHC = 3'd3;
  localparam logic [FuncW-1:0] FN_ROTC = 3'd4;
  localparam logic [FuncW-1:0] FN_LSHC = 3'd5;

  typedef logic [WordW-1:0] word_t;
  typedef logic [PairW-1:0] pair_t;

  typedef struct packed {
    logic [FuncW-1:0] func;
    logic             zero;
    logic             pass;
    logic             wl;
    logic             sign;
  } ctrl_t;

endpackage

// File: rtl/sru_if.sv
`timescale 1ns / 1ps
// sru_cmd_if / sru_res_if: valid/ready channels of the shift/rotate unit.
// Depends on sru_pkg.
interface sru_cmd_if;
  import sru_pkg::*;
  logic             valid;
  logic             ready;
  logic [FuncW-1:0] func;
  logic [EaW-1:0]   effective_address;
  word_t            acc_high;
  word_t            acc_low;
  modport source (output valid, func, effective_address, acc_high, acc_low, input ready);
  modport sink (input valid, func, effective_address, acc_high, acc_low, output ready);
endinterface

interface sru_res_if;
  import sru_pkg::*;
  logic  valid;
  logic  ready;
  word_t result_high;
  word_t result_low;
  logic  writes_low;
  modport source (output valid, result_high, result_low, writes_low, input ready);
  modport sink (input valid, result_high, result_low, writes_low, output ready);
endinterface

// File: rtl/shift_rotate_unit_36bit.sv
`timescale 1ns / 1ps
// shift_rotate_unit_36bit: six 36/72-bit shift and rotate ops as one 144-to-72 funnel.
// Depends on sru_pkg and sru_if.
// Pipeline: 3 register stages (decode, coarse shift, fine shift); an accepted item passes
// through them in that order, and res.valid rises once it sits in the fine-shift register.
// Throughput: one item per cycle; each stage stalls only when the one after it is full.
// Reset clears the stage valid bits only; data registers are not reset.
module shift_rotate_unit_36bit (
  input logic      clk,
  input logic      rst,
  sru_cmd_if.sink  cmd,
  sru_res_if.source res
);
  import sru_pkg::*;

  // stage valids and enables
  logic v1, v2, v3;
  logic en1, en2, en3;

  assign en3 = !v3 || res.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign cmd.ready = en1;

  // ---------------- stage 1: count decode and funnel setup
  logic        neg;
  logic [8:0]  c9;
  logic [8:0]  mag;
  logic [9:0]  u0, u1, u2;
  logic [6:0]  m72;
  logic [6:0]  m36;
  logic [6:0]  n35, n70;
  word_t       h, l;
  logic        s;
  logic [34:0] mag35;
  logic [69:0] mag70;
  pair_t       a_next, b_next;
  logic [KW-1:0] k_next;
  ctrl_t       ctrl_next;

  always_comb begin
    neg = cmd.effective_address[EaW-1];
    c9  = {neg, cmd.effective_address[7:0]};
    mag = neg ? (9'd0 - c9) : c9;
    // c + 288, then reduce modulo 72
    u0  = {2'b00, cmd.effective_address[7:0]} + (neg ? 10'd32 : 10'd288);
    u1  = (u0 >= 10'd288) ? (u0 - 10'd288) : u0;
    u2  = (u1 >= 10'd144) ? (u1 - 10'd144) : u1;
    m72 = (u2 >= 10'd72) ? 7'(u2 - 10'd72) : u2[6:0];
    m36 = (m72 >= 7'd36) ? (m72 - 7'd36) : m72;
    n35 = (mag >= 9'd35) ? 7'd35 : mag[6:0];
    n70 = (mag >= 9'd70) ? 7'd70 : mag[6:0];

    h     = cmd.acc_high;
    l     = cmd.acc_low;
    s     = h[WordW-1];
    mag35 = h[34:0];
    mag70 = {h[34:0], l[34:0]};

    a_next = '0;
    b_next = '0;
    k_next = '0;
    ctrl_next.func = cmd.func;
    ctrl_next.sign = s;
    ctrl_next.zero = 1'b0;
    ctrl_next.pass = 1'b0;
    ctrl_next.wl   = 1'b0;

    case (cmd.func)
      FN_ASH: begin
        if (neg) begin
          a_next = {PairW{s}};
          b_next = {mag35, 37'd0};
          k_next = 7'd72 - n35;
        end else begin
          a_next = {mag35, 37'd0};
          k_next = n35;
        end
      end
      FN_ROT: begin
        a_next = {h, h};
        k_next = m36;
      end
      FN_LSH: begin
        ctrl_next.zero = (mag >= 9'd36);
        if (neg) begin
          b_next = {h, 36'd0};
          k_next = 7'd72 - mag[6:0];
        end else begin
          a_next = {h, 36'd0};
          k_next = mag[6:0];
        end
      end
      FN_ASHC: begin
        ctrl_next.wl   = 1'b1;
        ctrl_next.pass = (mag == 9'd0);
        if (neg) begin
          a_next = {PairW{s}};
          b_next = {mag70, 2'b00};
          k_next = 7'd72 - n70;
        end else begin
          a_next = {mag70, 2'b00};
          k_next = n70;
        end
      end
      FN_ROTC: begin
        ctrl_next.wl = 1'b1;
        a_next = {h, l};
        b_next = {h, l};
        k_next = m72;
      end
      FN_LSHC: begin
        ctrl_next.wl   = 1'b1;
        ctrl_next.zero = (mag >= 9'd72);
        if (neg) begin
          b_next = {h, l};
          k_next = 7'd72 - mag[6:0];
        end else begin
          a_next = {h, l};
          k_next = mag[6:0];
        end
      end
      default: begin
        ctrl_next.pass = 1'b1;
      end
    endcase
  end

  pair_t         a1, b1;
  logic [KW-1:0] k1;
  ctrl_t         ctrl1;
  pair_t         acc1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= cmd.valid;
    end
    if (en1) begin
      a1    <= a_next;
      b1    <= b_next;
      k1    <= k_next;
      ctrl1 <= ctrl_next;
      acc1  <= {cmd.acc_high, cmd.acc_low};
    end
  end

  // ---------------- stage 2: coarse shift by multiples of 8
  logic [2*PairW-1:0] sh1;
  logic [PairW+6:0]   w2;
  logic [2:0]         k2;
  ctrl_t              ctrl2;
  pair_t              acc2;

  assign sh1 = {a1, b1} << {k1[KW-1:3], 3'b000};

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      w2    <= sh1[2*PairW-1:PairW-7];
      k2    <= k1[2:0];
      ctrl2 <= ctrl1;
      acc2  <= acc1;
    end
  end

  // ---------------- stage 3: fine shift and result assembly
  logic [PairW+6:0] sh2;
  pair_t            fo;
  word_t            rh_next, rl_next;
  word_t            h2, l2;

  always_comb begin
    sh2 = w2 << k2;
    fo  = sh2[PairW+6:7];
    h2  = acc2[PairW-1:WordW];
    l2  = acc2[WordW-1:0];
    rh_next = h2;
    rl_next = l2;
    case (ctrl2.func)
      FN_ASH:  rh_next = {ctrl2.sign, fo[71:37]};
      FN_ROT:  rh_next = fo[71:36];
      FN_LSH:  rh_next = ctrl2.zero ? '0 : fo[71:36];
      FN_ASHC: begin
        if (!ctrl2.pass) begin
          rh_next = {ctrl2.sign, fo[71:37]};
          rl_next = {ctrl2.sign, fo[36:2]};
        end
      end
      FN_ROTC: begin
        rh_next = fo[71:36];
        rl_next = fo[35:0];
      end
      FN_LSHC: begin
        rh_next = ctrl2.zero ? '0 : fo[71:36];
        rl_next = ctrl2.zero ? '0 : fo[35:0];
      end
      default: begin
        rh_next = h2;
        rl_next = l2;
      end
    endcase
  end

  ctrl_t ctrl3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      res.result_high <= rh_next;
      res.result_low  <= rl_next;
      res.writes_low  <= ctrl2.wl;
      ctrl3           <= ctrl2;
    end
  end

  assign res.valid = v3;

  // ---------------- assertions
  a_reset_clears: assert property (@(posedge clk)
    rst |=> (!v1 && !v2 && !v3))
    else $error("stage valids not cleared by reset");

  a_accept_loads: assert property (@(posedge clk) disable iff (rst)
    (cmd.valid && cmd.ready) |=> v1)
    else $error("accepted item missing from stage 1");

  a_mid_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !en2) |=> (v2 && $stable(w2) && $stable(ctrl2)))
    else $error("stalled stage 2 item lost or changed");

  a_ashc_sign: assert property (@(posedge clk) disable iff (rst)
    (res.valid && ctrl3.func == FN_ASHC && !ctrl3.pass) |->
      (res.result_high[WordW-1] == res.result_low[WordW-1]))
    else $error("double arithmetic shift lost low word sign copy");

  a_lshc_clear: assert property (@(posedge clk) disable iff (rst)
    (res.valid && ctrl3.func == FN_LSHC && ctrl3.zero) |->
      (res.result_high == '0 && res.result_low == '0))
    else $error("long double logical shift did not clear pair");

endmodule

// File: dv/sru_result_monitor.sv
`timescale 1ns / 1ps
// sru_result_monitor: watches the command and result channels of the shift/rotate unit,
// predicts each accumulator write and compares it with the result item in order.
// Depends on sru_pkg and sru_if.
module sru_result_monitor (
  input  logic clk,
  input  logic rst,
  sru_cmd_if   cmd,
  sru_res_if   res,
  output int   mismatches,
  output int   awaiting
);
  import sru_pkg::*;

  typedef struct packed {
    word_t high;
    word_t low;
    logic  wl;
  } acc_write_t;

  acc_write_t writes_due[$];
  int errs = 0;

  function automatic acc_write_t shift_accumulators(logic [FuncW-1:0] fn,
                                                    logic [EaW-1:0] ea,
                                                    word_t hi, word_t lo);
    acc_write_t r;
    int cnt;
    int n;
    logic [PairW-1:0] pair;
    logic [2*WordW-1:0] t72;
    logic [2*PairW-1:0] t144;
    logic [70:0] mag;
    logic [69:0] m70;
    cnt = int'(ea[7:0]);
    if (ea[EaW-1]) cnt -= 256;
    pair = {hi, lo};
    r.high = hi;
    r.low = lo;
    r.wl = 1'b0;
    case (fn)
      FN_ASH: begin
        if (cnt >= 0) r.high = {hi[35], hi[34:0] << cnt};
        else r.high = $signed(hi) >>> (-cnt);
      end
      FN_ROT: begin
        n = ((cnt % 36) + 36) % 36;
        t72 = {hi, hi} << n;
        r.high = t72[71:36];
      end
      FN_LSH: begin
        if (cnt >= 0) r.high = hi << cnt;
        else r.high = hi >> (-cnt);
      end
      FN_ASHC: begin
        r.wl = 1'b1;
        n = cnt;
        if (n > 70) n = 70;
        if (n < -70) n = -70;
        if (n != 0) begin
          if (n > 0) begin
            m70 = {hi[34:0], lo[34:0]} << n;
          end else begin
            mag = $signed({hi[35], hi[34:0], lo[34:0]}) >>> (-n);
            m70 = mag[69:0];
          end
          // low word's top bit is a copy of the sign, not data
          r.high = {hi[35], m70[69:35]};
          r.low = {hi[35], m70[34:0]};
        end
      end
      FN_ROTC: begin
        r.wl = 1'b1;
        n = ((cnt % 72) + 72) % 72;
        t144 = {pair, pair} << n;
        {r.high, r.low} = t144[143:72];
      end
      FN_LSHC: begin
        r.wl = 1'b1;
        if (cnt >= 0) {r.high, r.low} = pair << cnt;
        else {r.high, r.low} = pair >> (-cnt);
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    acc_write_t want;
    if (!rst) begin
      if (res.valid && res.ready) begin
        if (writes_due.size() == 0) begin
          $error("result item with nothing outstanding: high %012o low %012o",
                 res.result_high, res.result_low);
          errs++;
        end else begin
          want = writes_due.pop_front();
          if (res.result_high !== want.high) begin
            $error("result_high: expected %012o, got %012o", want.high, res.result_high);
            errs++;
          end
          if (res.result_low !== want.low) begin
            $error("result_low: expected %012o, got %012o", want.low, res.result_low);
            errs++;
          end
          if (res.writes_low !== want.wl) begin
            $error("writes_low: expected %0b, got %0b", want.wl, res.writes_low);
            errs++;
          end
        end
      end
      if (cmd.valid && cmd.ready)
        writes_due.push_back(shift_accumulators(cmd.func, cmd.effective_address,
                                                cmd.acc_high, cmd.acc_low));
    end
    mismatches <= errs;
    awaiting <= writes_due.size();
  end

endmodule

// File: dv/shift_rotate_unit_36bit_tb.sv
`timescale 1ns / 1ps
// shift_rotate_unit_36bit_tb: drives shift/rotate items in random bursts against a stalling
// receiver and gives the verdict from sru_result_monitor.
// Depends on sru_pkg, sru_if, shift_rotate_unit_36bit and sru_result_monitor.
module shift_rotate_unit_36bit_tb;
  import sru_pkg::*;

  localparam logic [FuncW-1:0] FN_SPARE6 = 3'd6;
  localparam logic [FuncW-1:0] FN_SPARE7 = 3'd7;
  localparam int RandomItems = 850;
  localparam int StallLimit  = 3000;
  localparam int LongHold    = 300;

  logic clk;
  logic rst;
  int   mismatches;
  int   awaiting;
  int   idle_cycles = 0;
  int   burst_left = 0;

  sru_cmd_if cmd_ch ();
  sru_res_if res_ch ();

  shift_rotate_unit_36bit dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .res (res_ch)
  );

  sru_result_monitor result_chk (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd_ch),
    .res        (res_ch),
    .mismatches (mismatches),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // sign in bit 17, count in bits 7:0, the bits between are don't-care
  function automatic logic [EaW-1:0] ea_for(int cnt);
    logic [EaW-1:0] ea;
    ea = {cnt < 0, 9'($urandom), cnt[7:0]};
    return ea;
  endfunction

  function automatic int pick_count();
    int corners [8] = '{0, 1, 35, 36, 70, 71, 72, 73};
    int c;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: c = int'($urandom_range(0, 80)) - 40;
      5, 6: begin
        c = corners[$urandom_range(0, 7)];
        if ($urandom_range(0, 1) == 1) c = -c;
      end
      default: c = int'($urandom_range(0, 511)) - 256;
    endcase
    return c;
  endfunction

  function automatic word_t pick_word();
    word_t w;
    case ($urandom_range(0, 7))
      0: w = '0;
      1: w = '1;
      2: w = word_t'(1) << $urandom_range(0, 35);
      3: w = ~(word_t'(1) << $urandom_range(0, 35));
      default: w = word_t'({$urandom, $urandom});
    endcase
    return w;
  endfunction

  function automatic logic [FuncW-1:0] pick_func();
    logic [FuncW-1:0] f;
    case ($urandom_range(0, 39))
      0: f = FN_SPARE6;
      1: f = FN_SPARE7;
      default: begin
        case ($urandom_range(0, 5))
          0: f = FN_ASH;
          1: f = FN_ROT;
          2: f = FN_LSH;
          3: f = FN_ASHC;
          4: f = FN_ROTC;
          default: f = FN_LSHC;
        endcase
      end
    endcase
    return f;
  endfunction

  task automatic send_shift(input logic [FuncW-1:0] fn, input int cnt,
                            input word_t hi, input word_t lo);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 9);
      if (gap != 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.func <= fn;
    cmd_ch.effective_address <= ea_for(cnt);
    cmd_ch.acc_high <= hi;
    cmd_ch.acc_low <= lo;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    burst_left--;
  endtask

  initial begin
    rst <= 1'b1;
    cmd_ch.valid <= 1'b0;
    cmd_ch.func <= '0;
    cmd_ch.effective_address <= '0;
    cmd_ch.acc_high <= '0;
    cmd_ch.acc_low <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_shift(FN_ASH, 0, 36'o123456701234, 36'o0);
    send_shift(FN_ASH, 35, 36'o777777777777, 36'o0);
    send_shift(FN_ASH, -35, 36'o400000000001, 36'o0);
    send_shift(FN_ASH, 255, 36'o377777777777, 36'o0);
    send_shift(FN_ASH, -256, 36'o377777777777, 36'o0);
    send_shift(FN_ROT, 36, 36'o123456701234, 36'o0);
    send_shift(FN_ROT, -1, 36'o000000000001, 36'o0);
    send_shift(FN_ROT, 71, 36'o400000000000, 36'o0);
    send_shift(FN_LSH, 36, 36'o777777777777, 36'o0);
    send_shift(FN_LSH, -36, 36'o777777777777, 36'o0);
    send_shift(FN_LSH, 35, 36'o000000000001, 36'o0);
    send_shift(FN_LSH, -35, 36'o400000000000, 36'o0);
    send_shift(FN_ASHC, 70, 36'o000000000000, 36'o000000000001);
    send_shift(FN_ASHC, 71, 36'o400000000000, 36'o377777777777);
    send_shift(FN_ASHC, -70, 36'o400000000000, 36'o000000000000);
    send_shift(FN_ASHC, -100, 36'o377777777777, 36'o777777777777);
    send_shift(FN_ASHC, 0, 36'o000000000000, 36'o400000000000);
    send_shift(FN_ASHC, 1, 36'o400000000000, 36'o777777777777);
    send_shift(FN_ROTC, 36, 36'o111111111111, 36'o222222222222);
    send_shift(FN_ROTC, -72, 36'o123456701234, 36'o765432107654);
    send_shift(FN_ROTC, 1, 36'o400000000000, 36'o400000000000);
    send_shift(FN_LSHC, 72, 36'o777777777777, 36'o777777777777);
    send_shift(FN_LSHC, -72, 36'o777777777777, 36'o777777777777);
    send_shift(FN_LSHC, 71, 36'o000000000000, 36'o000000000001);
    send_shift(FN_SPARE6, 5, 36'o123456701234, 36'o765432107654);
    send_shift(FN_SPARE7, -5, 36'o777777777777, 36'o000000000000);

    repeat (RandomItems) send_shift(pick_func(), pick_count(), pick_word(), pick_word());
    cmd_ch.valid <= 1'b0;

    // awaiting is a registered copy of the monitor's outstanding count
    @(posedge clk);
    while (awaiting != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // receiver: segments of steady, coin-flip, dense or sparse ready, plus one long hold-off
  initial begin : res_stall
    int mode;
    int span;
    int seg;
    res_ch.ready <= 1'b0;
    seg = 0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      seg++;
      if (seg == 10) begin
        res_ch.ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(8, 60);
      repeat (span) begin
        case (mode)
          0: res_ch.ready <= 1'b1;
          1: res_ch.ready <= ($urandom_range(0, 1) == 1);
          2: res_ch.ready <= ($urandom_range(0, 7) != 0);
          default: res_ch.ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (res_ch.valid && res_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// File: shift_rotate_unit_36bit.f
rtl/sru_pkg.sv
rtl/sru_if.sv
rtl/shift_rotate_unit_36bit.sv
dv/sru_result_monitor.sv
dv/shift_rotate_unit_36bit_tb.sv
